>>> sv/c3rb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c3rb_pkg
// Shared widths, register indexes, reset values and word types of the 3x3
// replicate-border convolution core.
// ----------------------------------------------------------------------------
package c3rb_pkg;

    localparam int PIXEL_BITS       = 16;
    localparam int COEF_BITS        = 16;
    localparam int FILTERED_BITS    = 35;
    localparam int ACC_BITS         = PIXEL_BITS + COEF_BITS + 4;
    localparam int SIZE_BITS        = 11;
    localparam int COEF_REG_BITS    = 48;
    localparam int CFG_INDEX_BITS   = 8;
    localparam int TAPS             = 9;
    localparam int MAX_SIZE_DEFAULT = 1024;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_SIZE  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_TOP    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_MID    = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_BOTTOM = CFG_INDEX_BITS'(3);

    localparam logic KIND_PIXEL = 1'b0;

    localparam logic [SIZE_BITS-1:0]     SIZE_RESET       = 11'd1024;
    localparam logic [COEF_REG_BITS-1:0] COEF_TOP_RESET    = 48'd4295032834;
    localparam logic [COEF_REG_BITS-1:0] COEF_MID_RESET    = 48'd65537;
    localparam logic [COEF_REG_BITS-1:0] COEF_BOTTOM_RESET = 48'd8590000128;

    typedef struct packed {
        logic                         kind;
        logic signed [PIXEL_BITS-1:0] pixel;
    } in_word_t;

    typedef struct packed {
        logic signed [FILTERED_BITS-1:0] filtered;
        logic                            last_of_image;
    } out_word_t;

    typedef logic [2:0][COEF_REG_BITS-1:0] coef_rows_t;

    typedef logic [TAPS-1:0][PIXEL_BITS-1:0] tap_vec_t;

    typedef struct packed {
        logic                       last;
        logic signed [ACC_BITS-1:0] sum;
        tap_vec_t                   taps;
    } chain_t;

    typedef struct packed {
        logic                         valid;
        logic                         load_only;
        logic                         emit;
        logic                         fill;
        logic                         prep_after;
        logic                         top_mid;
        logic                         bot_px;
        logic                         last;
        logic                         wr;
        logic signed [PIXEL_BITS-1:0] pixel;
    } win_cmd_t;

endpackage
`default_nettype wire

>>> sv/c3rb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c3rb_ctrl
// Configuration registers and raster counters. Decides for each accepted
// word how the window is loaded, shifted and emitted.
// ----------------------------------------------------------------------------
module c3rb_ctrl #(
    parameter int MAX_SIZE = c3rb_pkg::MAX_SIZE_DEFAULT,
    localparam int ADDR_W = $clog2(MAX_SIZE)
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       en,
    input  wire logic                                       in_valid,
    input  wire c3rb_pkg::in_word_t                         in_word,
    input  wire logic                                       cfg_write,
    input  wire logic [c3rb_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  wire logic [c3rb_pkg::COEF_REG_BITS-1:0]         cfg_data,
    output c3rb_pkg::coef_rows_t                            coef_rows,
    output c3rb_pkg::win_cmd_t                              cmd,
    output logic [ADDR_W-1:0]                               addr
);

    localparam int CNT_W = $clog2(MAX_SIZE + 2);

    logic [c3rb_pkg::SIZE_BITS-1:0] size_reg;
    c3rb_pkg::coef_rows_t           coef_reg;
    logic [CNT_W-1:0] in_row_reg, in_col_reg, orow_reg, ocol_reg;
    logic [CNT_W-1:0] in_row_next, in_col_next, orow_next, ocol_next;
    logic [CNT_W-1:0] n;
    logic             is_px, act, prep0, emit, fill, prep_after, last;

    always_comb
    begin
        if (size_reg == '0)
            n = CNT_W'(1);
        else if (32'(size_reg) > 32'(MAX_SIZE))
            n = CNT_W'(MAX_SIZE);
        else
            n = CNT_W'(size_reg);
    end

    always_comb
    begin
        is_px      = (in_word.kind == c3rb_pkg::KIND_PIXEL);
        act        = in_valid && en && (is_px == (in_row_reg < n));
        prep0      = (in_row_reg == CNT_W'(1)) && (in_col_reg == '0);
        emit       = (in_row_reg >= CNT_W'(2))
                     || ((in_row_reg == CNT_W'(1)) && (in_col_reg != '0));
        fill       = emit && ((ocol_reg + CNT_W'(1)) < n);
        prep_after = emit && ((ocol_reg + CNT_W'(1)) == n)
                     && ((orow_reg + CNT_W'(1)) < n);
        last       = emit && ((ocol_reg + CNT_W'(1)) == n)
                     && ((orow_reg + CNT_W'(1)) == n);

        cmd.valid      = act;
        cmd.load_only  = prep0;
        cmd.emit       = emit;
        cmd.fill       = fill;
        cmd.prep_after = prep_after;
        cmd.top_mid    = prep0 || (fill && (orow_reg == '0));
        if (prep0)
            cmd.bot_px = (n > CNT_W'(1));
        else if (fill)
            cmd.bot_px = ((orow_reg + CNT_W'(1)) < n);
        else
            cmd.bot_px = ((orow_reg + CNT_W'(2)) < n);
        cmd.last  = last;
        cmd.wr    = act && is_px;
        cmd.pixel = in_word.pixel;
        addr      = in_col_reg[ADDR_W-1:0];
    end

    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        if (act)
        begin
            if (last)
            begin
                in_row_next = '0;
                in_col_next = '0;
                orow_next   = '0;
                ocol_next   = '0;
            end
            else
            begin
                if ((in_col_reg + CNT_W'(1)) == n)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + CNT_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + CNT_W'(1);
                end
                if (emit)
                begin
                    if ((ocol_reg + CNT_W'(1)) == n)
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= c3rb_pkg::SIZE_RESET;
            coef_reg[0] <= c3rb_pkg::COEF_TOP_RESET;
            coef_reg[1] <= c3rb_pkg::COEF_MID_RESET;
            coef_reg[2] <= c3rb_pkg::COEF_BOTTOM_RESET;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            orow_reg    <= '0;
            ocol_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                c3rb_pkg::REG_IMAGE_SIZE:
                begin
                    size_reg   <= cfg_data[c3rb_pkg::SIZE_BITS-1:0];
                    in_row_reg <= '0;
                    in_col_reg <= '0;
                    orow_reg   <= '0;
                    ocol_reg   <= '0;
                end
                c3rb_pkg::REG_COEF_TOP:    coef_reg[0] <= cfg_data;
                c3rb_pkg::REG_COEF_MID:    coef_reg[1] <= cfg_data;
                c3rb_pkg::REG_COEF_BOTTOM: coef_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
        else
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
        end
    end

    assign coef_rows = coef_reg;

endmodule
`default_nettype wire

>>> sv/c3rb_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c3rb_window
// Line store of the two previous rows and the 3x3 window. Reads one column
// per word, updates the window and presents the taps of each output.
// ----------------------------------------------------------------------------
module c3rb_window #(
    parameter int MAX_SIZE = c3rb_pkg::MAX_SIZE_DEFAULT,
    localparam int ADDR_W = $clog2(MAX_SIZE)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire c3rb_pkg::win_cmd_t    cmd,
    input  wire logic [ADDR_W-1:0]     addr,
    output logic                       tap_valid,
    output logic                       tap_last,
    output c3rb_pkg::tap_vec_t         taps
);

    localparam int P = c3rb_pkg::PIXEL_BITS;

    logic [2*P-1:0]           mem [MAX_SIZE];
    logic [2*P-1:0]           rd_reg, fwd_data_reg, rd_eff, wr_entry;
    logic                     fwd_reg;
    c3rb_pkg::win_cmd_t       cmd_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [2:0][2:0][P-1:0]   win_reg, win_next, shifted;
    logic [2:0][P-1:0]        col;
    logic [P-1:0]             up_val, mid_val;
    c3rb_pkg::tap_vec_t       taps_reg, taps_next;
    logic                     tap_valid_reg, tap_last_reg;

    // The upper entry takes the old middle entry, the middle takes the pixel.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg <= mem[addr];
            if (cmd_reg.valid && cmd_reg.wr)
                mem[addr_reg] <= wr_entry;
        end
    end

    always_comb
    begin
        rd_eff   = fwd_reg ? fwd_data_reg : rd_reg;
        up_val   = rd_eff[2*P-1:P];
        mid_val  = rd_eff[P-1:0];
        col[0]   = cmd_reg.top_mid ? mid_val : up_val;
        col[1]   = mid_val;
        col[2]   = cmd_reg.bot_px ? cmd_reg.pixel : mid_val;
        wr_entry = {mid_val, cmd_reg.pixel};

        for (int r = 0; r < 3; r++)
        begin
            shifted[r][0] = win_reg[r][1];
            shifted[r][1] = win_reg[r][2];
            shifted[r][2] = cmd_reg.fill ? col[r] : win_reg[r][2];
        end

        win_next = win_reg;
        if (cmd_reg.valid)
        begin
            if (cmd_reg.load_only || cmd_reg.prep_after)
            begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        win_next[r][c] = col[r];
            end
            else if (cmd_reg.emit)
            begin
                win_next = shifted;
            end
        end

        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                taps_next[r*3+c] = shifted[r][c];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= '0;
            fwd_reg       <= 1'b0;
            win_reg       <= '0;
            tap_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            cmd_reg       <= cmd;
            fwd_reg       <= cmd_reg.valid && cmd_reg.wr && cmd.valid && (addr == addr_reg);
            win_reg       <= win_next;
            tap_valid_reg <= cmd_reg.valid && cmd_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_reg     <= addr;
            fwd_data_reg <= wr_entry;
            tap_last_reg <= cmd_reg.last;
            taps_reg     <= taps_next;
        end
    end

    assign tap_valid = tap_valid_reg;
    assign tap_last  = tap_last_reg;
    assign taps      = taps_reg;

endmodule
`default_nettype wire

>>> sv/c3rb_mac_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c3rb_mac_cell
// One multiply-accumulate cell of the sum chain. Weights the lowest tap,
// adds it to the running sum and hands the word to the next cell.
// ----------------------------------------------------------------------------
module c3rb_mac_cell (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  prev_valid,
    input  wire c3rb_pkg::chain_t                      prev_word,
    input  wire logic signed [c3rb_pkg::COEF_BITS-1:0] weight,
    output logic                                       next_valid,
    output c3rb_pkg::chain_t                           next_word
);

    localparam int P   = c3rb_pkg::PIXEL_BITS;
    localparam int C   = c3rb_pkg::COEF_BITS;
    localparam int ACC = c3rb_pkg::ACC_BITS;
    localparam int T   = c3rb_pkg::TAPS;

    logic signed [P-1:0]   tap;
    logic signed [P+C-1:0] prod;
    c3rb_pkg::chain_t      word_next, word_reg;
    logic                  valid_reg;

    assign tap  = prev_word.taps[0];
    assign prod = tap * weight;

    always_comb
    begin
        word_next.last         = prev_word.last;
        word_next.sum          = prev_word.sum + ACC'(prod);
        word_next.taps[T-2:0]  = prev_word.taps[T-1:1];
        word_next.taps[T-1]    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign next_valid = valid_reg;
    assign next_word  = word_reg;

endmodule
`default_nettype wire

>>> sv/conv3x3_replicate_border_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_core
// Streaming 3x3 convolution of a square image with replicated borders.
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall   in_word  (kind, pixel)
//   out      output     out_valid / out_stall out_word (filtered, last_of_image)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word is accepted per cycle while no result is stalled; each result is
// registered through the line store read, the window stage and the
// nine-cell multiply-accumulate chain.
// A stalled result freezes the whole pipeline, and in_stall follows it.
// Reset clears counters, window and valid bits; the line store is not cleared.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border_core #(
    parameter int MAX_SIZE = c3rb_pkg::MAX_SIZE_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire c3rb_pkg::in_word_t                  in_word,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output c3rb_pkg::out_word_t                      out_word,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [c3rb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [c3rb_pkg::COEF_REG_BITS-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MAX_SIZE);
    localparam int C      = c3rb_pkg::COEF_BITS;
    localparam int T      = c3rb_pkg::TAPS;

    logic                   en;
    c3rb_pkg::coef_rows_t   coef_rows;
    c3rb_pkg::win_cmd_t     cmd;
    logic [ADDR_W-1:0]      addr;
    logic                   tap_valid, tap_last;
    c3rb_pkg::tap_vec_t     taps;
    logic [T-1:0][C-1:0]    weights;
    c3rb_pkg::chain_t       chain_word [T+1];
    logic [T:0]             chain_valid;

    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    c3rb_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef_rows (coef_rows),
        .cmd       (cmd),
        .addr      (addr)
    );

    c3rb_window #(
        .MAX_SIZE (MAX_SIZE)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cmd       (cmd),
        .addr      (addr),
        .tap_valid (tap_valid),
        .tap_last  (tap_last),
        .taps      (taps)
    );

    assign chain_valid[0]     = tap_valid;
    assign chain_word[0].last = tap_last;
    assign chain_word[0].sum  = '0;
    assign chain_word[0].taps = taps;

    for (genvar k = 0; k < T; k++)
    begin : g_cell
        assign weights[k] = coef_rows[k/3][(k%3)*C +: C];

        c3rb_mac_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (chain_valid[k]),
            .prev_word  (chain_word[k]),
            .weight     (weights[k]),
            .next_valid (chain_valid[k+1]),
            .next_word  (chain_word[k+1])
        );
    end

    assign out_valid              = chain_valid[T];
    assign out_word.filtered      = chain_word[T].sum[c3rb_pkg::FILTERED_BITS-1:0];
    assign out_word.last_of_image = chain_word[T].last;

endmodule
`default_nettype wire

>>> tb/sv/conv3x3_replicate_border_check.sv
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_check
// Watches the configuration, input and output channels of the 3x3 convolution
// core. It keeps its own copy of the registers, line stores, window and raster
// counters, and works out the expected result word for every accepted input
// word. Each accepted output word is compared field by field with the oldest
// expected word. Mismatch and pending counts are handed to the test top.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border_check
    import c3rb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  in_word_t                  in_word,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  out_word_t                 out_word,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_REG_BITS-1:0]  cfg_data,
    output int                        errors,
    output int                        outstanding
);

    localparam int LINE_DEPTH   = MAX_SIZE_DEFAULT;
    localparam int REPORT_LIMIT = 10;

    logic [SIZE_BITS-1:0]         side_reg;
    logic [COEF_REG_BITS-1:0]     weight_rows [3];
    logic signed [PIXEL_BITS-1:0] upper_row [LINE_DEPTH];
    logic signed [PIXEL_BITS-1:0] middle_row [LINE_DEPTH];
    longint                       taps [9];
    int unsigned                  row_pos;
    int unsigned                  col_pos;
    int unsigned                  sums_done;
    out_word_t                    expected_sums [$];
    int                           mismatch_count;

    function automatic int unsigned side_len();
        if (side_reg == '0)
            return 1;
        if (side_reg > LINE_DEPTH)
            return LINE_DEPTH;
        return int'(side_reg);
    endfunction

    function automatic void load_column(int s, int unsigned row, int unsigned col,
                                        int unsigned n, longint px);
        int unsigned k;
        longint      mid;
        k = col % LINE_DEPTH;
        mid = longint'(middle_row[k]);
        taps[s] = (row == 0) ? mid : longint'(upper_row[k]);
        taps[3 + s] = mid;
        taps[6 + s] = (row + 1 < n) ? px : mid;
    endfunction

    function automatic void start_row(int unsigned row, int unsigned n, longint px);
        int r;
        load_column(0, row, 0, n, px);
        for (r = 0; r < 3; r++)
        begin
            taps[r * 3 + 1] = taps[r * 3];
            taps[r * 3 + 2] = taps[r * 3];
        end
    endfunction

    function automatic bit convolve_word(input in_word_t w, output out_word_t res);
        int unsigned n;
        int unsigned total;
        int unsigned p;
        int unsigned orow;
        int unsigned ocol;
        int unsigned k;
        longint      px;
        longint      sum;
        longint      weight;
        bit          is_px;
        bit          last;
        bit          produced;
        int          r;
        int          c;
        n = side_len();
        total = n * n;
        p = row_pos * n + col_pos;
        is_px = (w.kind == KIND_PIXEL);
        px = longint'($signed(w.pixel));
        last = 1'b0;
        produced = 1'b0;
        res = '0;
        if (is_px && p >= total)
            return 1'b0;
        if (!is_px && p < total)
            return 1'b0;
        if (p == n)
            start_row(0, n, px);
        if (p >= n + 1)
        begin
            orow = sums_done / n;
            ocol = sums_done % n;
            for (r = 0; r < 3; r++)
            begin
                taps[r * 3] = taps[r * 3 + 1];
                taps[r * 3 + 1] = taps[r * 3 + 2];
            end
            if (ocol + 1 < n)
                load_column(2, orow, ocol + 1, n, px);
            sum = 0;
            for (r = 0; r < 3; r++)
            begin
                for (c = 0; c < 3; c++)
                begin
                    weight = longint'($signed(weight_rows[r][c * COEF_BITS +: COEF_BITS]));
                    sum += weight * taps[r * 3 + c];
                end
            end
            sums_done++;
            last = (sums_done == total);
            res.filtered = sum[FILTERED_BITS-1:0];
            res.last_of_image = last;
            produced = 1'b1;
            if (ocol + 1 == n && orow + 1 < n)
                start_row(orow + 1, n, px);
        end
        if (is_px)
        begin
            k = col_pos % LINE_DEPTH;
            upper_row[k] = middle_row[k];
            middle_row[k] = w.pixel;
        end
        col_pos++;
        if (col_pos >= n)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (last)
        begin
            row_pos = 0;
            col_pos = 0;
            sums_done = 0;
        end
        return produced;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t predicted;
        out_word_t oldest;
        int        i;
        if (!rst_n)
        begin
            side_reg = SIZE_RESET;
            weight_rows[0] = COEF_TOP_RESET;
            weight_rows[1] = COEF_MID_RESET;
            weight_rows[2] = COEF_BOTTOM_RESET;
            for (i = 0; i < 9; i++)
                taps[i] = 0;
            row_pos = 0;
            col_pos = 0;
            sums_done = 0;
            expected_sums.delete();
            mismatch_count = 0;
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_SIZE)
                begin
                    side_reg = cfg_data[SIZE_BITS-1:0];
                    row_pos = 0;
                    col_pos = 0;
                    sums_done = 0;
                end
                else if (cfg_index == REG_COEF_TOP)
                    weight_rows[0] = cfg_data;
                else if (cfg_index == REG_COEF_MID)
                    weight_rows[1] = cfg_data;
                else if (cfg_index == REG_COEF_BOTTOM)
                    weight_rows[2] = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (convolve_word(in_word, predicted))
                    expected_sums.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_sums.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected output word: filtered=%0d last_of_image=%0b",
                                 out_word.filtered, out_word.last_of_image);
                end
                else
                begin
                    oldest = expected_sums.pop_front();
                    if (out_word.filtered !== oldest.filtered ||
                        out_word.last_of_image !== oldest.last_of_image)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                     oldest.filtered, oldest.last_of_image,
                                     out_word.filtered, out_word.last_of_image);
                    end
                end
            end
            errors <= mismatch_count;
            outstanding <= expected_sums.size();
        end
    end

endmodule

>>> tb/sv/conv3x3_replicate_border_core_test.sv
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_core_test
// Drives the 3x3 convolution core with pixel and drain words and register
// writes: a partial full-size image under reset settings, a short directed
// set of border and extreme cases, then random images of mostly small sizes
// with random weights, ignored words and interrupted images. The sender works
// in bursts, the receiver stalls on its own pattern, and a separate checker
// predicts and compares every output word.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border_core_test;
    import c3rb_pkg::*;

    localparam logic                      KIND_DRAIN       = 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = CFG_INDEX_BITS'(4);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_UNUSED  = '1;
    localparam int RANDOM_ITEMS     = 520;
    localparam int BIG_IMAGE_PIXELS = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 30;
    localparam int CYCLE_LIMIT      = 500000;

    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    in_word_t                  in_word;
    logic                      out_valid;
    logic                      out_stall;
    out_word_t                 out_word;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COEF_REG_BITS-1:0]  cfg_data;
    logic                      long_hold_go;
    int                        errors;
    int                        outstanding;
    int                        burst_left;
    int                        random_items;
    int                        cycle_count;

    conv3x3_replicate_border_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conv3x3_replicate_border_check checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("conv3x3_replicate_border_core_test: FAIL");
        $finish;
    end

    initial
    begin : receiver
        flow_mode_t mode;
        int         mode_left;
        int         phase;
        bit         held;
        out_stall = 1'b0;
        mode = FLOW_FREE;
        mode_left = 0;
        phase = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_go && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = flow_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(1, 80);
                end
                mode_left--;
                phase++;
                case (mode)
                    FLOW_FREE:  out_stall <= 1'b0;
                    FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:    out_stall <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_REG_BITS-1:0] rand_weights();
        case ($urandom_range(0, 7))
            0:       return {3{16'h8000}};
            1:       return {3{16'h7FFF}};
            2:       return '0;
            3:       return '1;
            4:       return {16'($urandom_range(0, 8)) - 16'd4,
                             16'($urandom_range(0, 8)) - 16'd4,
                             16'($urandom_range(0, 8)) - 16'd4};
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic int pick_side();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            15, 16:  return $urandom_range(7, 12);
            17:      return 16;
            18:      return $urandom_range(17, 20);
            default: return $urandom_range(3, 6);
        endcase
    endfunction

    task automatic send_word(input logic kind, input logic [PIXEL_BITS-1:0] pix);
        in_word_t w;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 2);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        w.kind = kind;
        w.pixel = pix;
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_pixels(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_word(KIND_PIXEL, rand_pixel());
    endtask

    task automatic send_drains(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_word(KIND_DRAIN, 16'($urandom));
    endtask

    task automatic run_image(input int n, input bit noisy);
        int i;
        for (i = 0; i < n * n; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(KIND_DRAIN, 16'($urandom));
            send_word(KIND_PIXEL, rand_pixel());
        end
        for (i = 0; i <= n; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_word(KIND_PIXEL, rand_pixel());
            send_word(KIND_DRAIN, 16'($urandom));
        end
        random_items += n * n + n + 1;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [COEF_REG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_side(input int value);
        logic [COEF_REG_BITS-1:0] data;
        data = {16'($urandom), 32'($urandom)};
        data[SIZE_BITS-1:0] = value[SIZE_BITS-1:0];
        write_reg(REG_IMAGE_SIZE, data);
    endtask

    task automatic write_weights(input logic [COEF_REG_BITS-1:0] top,
                                 input logic [COEF_REG_BITS-1:0] mid,
                                 input logic [COEF_REG_BITS-1:0] bottom);
        write_reg(REG_COEF_TOP, top);
        write_reg(REG_COEF_MID, mid);
        write_reg(REG_COEF_BOTTOM, bottom);
    endtask

    task automatic release_cfg();
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        int settled;
        in_valid <= 1'b0;
        burst_left = 0;
        do
        begin
            while (outstanding != 0)
                @(posedge clk);
            settled = 0;
            while (settled < SETTLE_CYCLES)
            begin
                @(posedge clk);
                if (!out_stall)
                    settled++;
            end
        end
        while (outstanding != 0);
    endtask

    initial
    begin : stimulus
        int side_now;
        int raw;
        int count;
        bit need_side;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        long_hold_go = 1'b0;
        burst_left = 0;
        random_items = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_pixels(BIG_IMAGE_PIXELS);
        wait_idle();

        write_side(3);
        release_cfg();
        run_image(3, 1'b0);
        wait_idle();

        write_weights({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        write_side(2);
        release_cfg();
        send_word(KIND_PIXEL, 16'h8000);
        send_word(KIND_PIXEL, 16'h8000);
        send_word(KIND_PIXEL, 16'h8000);
        send_word(KIND_PIXEL, 16'h8000);
        send_drains(3);
        wait_idle();

        write_weights({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        release_cfg();
        send_word(KIND_PIXEL, 16'h8000);
        send_word(KIND_PIXEL, 16'h8000);
        send_word(KIND_PIXEL, 16'h8000);
        send_word(KIND_PIXEL, 16'h8000);
        send_drains(3);
        wait_idle();

        write_side(0);
        write_weights({16'h0003, 16'hFFFE, 16'h0001}, '1, {16'h7FFF, 16'h0000, 16'h8000});
        release_cfg();
        send_word(KIND_DRAIN, 16'hFFFF);
        send_word(KIND_PIXEL, 16'h7FFF);
        send_word(KIND_PIXEL, 16'hFFFF);
        send_drains(2);
        wait_idle();

        write_reg(REG_LAST_UNUSED, '1);
        write_side(1);
        release_cfg();
        send_word(KIND_DRAIN, 16'h0000);
        send_word(KIND_PIXEL, 16'h5A5A);
        send_drains(2);
        wait_idle();

        write_side(2047);
        write_weights(rand_weights(), rand_weights(), rand_weights());
        release_cfg();
        send_pixels(BIG_IMAGE_PIXELS);
        wait_idle();

        write_side(8);
        write_weights(rand_weights(), rand_weights(), rand_weights());
        release_cfg();
        long_hold_go <= 1'b1;
        run_image(8, 1'b0);

        side_now = 8;
        need_side = 1'b0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            if (need_side || $urandom_range(0, 3) == 0)
            begin
                raw = pick_side();
                write_side(raw);
                side_now = (raw == 0) ? 1 : raw;
            end
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_COEF_TOP, rand_weights());
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_COEF_MID, rand_weights());
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_COEF_BOTTOM, rand_weights());
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_FIRST_UNUSED + CFG_INDEX_BITS'($urandom_range(0, 251)),
                          {16'($urandom), 32'($urandom)});
            release_cfg();
            if ($urandom_range(0, 9) < 8)
            begin
                run_image(side_now, $urandom_range(0, 2) == 0);
                need_side = 1'b0;
            end
            else
            begin
                count = $urandom_range(1, side_now * side_now);
                send_pixels(count);
                random_items += count;
                need_side = $urandom_range(0, 1);
            end
        end
        wait_idle();

        if (errors == 0 && outstanding == 0)
            $display("conv3x3_replicate_border_core_test: PASS");
        else
            $display("conv3x3_replicate_border_core_test: FAIL");
        $finish;
    end

endmodule
